FILE: rtl/core/rbd_pkg.sv
// Shared types, constants and command codes for the retry backoff decider.
package rbd_pkg;

    // Delay range in whole milliseconds; the working delay carries 16 fraction bits
    localparam int DELAY_BITS = 32;
    localparam int DQ_W       = DELAY_BITS + 16;
    localparam int GP_W       = DQ_W + 16;
    localparam int MUL_A_W    = (DELAY_BITS > 32) ? DELAY_BITS : 32;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int DLY_W      = 33;
    localparam int FACT_W     = 18;

    localparam logic [63:0] DELAY_LIM  = (64'd1 << DELAY_BITS) - 64'd1;
    localparam logic [63:0] SEED_SUBST = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MULT   = 64'h2545_F491_4F6C_DD1D;
    localparam logic [16:0] ONE_Q16    = 17'h1_0000;

    // Configuration register indexes
    localparam logic [2:0] REG_ATTEMPT_LIMIT = 3'd0;
    localparam logic [2:0] REG_BASE_DELAY    = 3'd1;
    localparam logic [2:0] REG_CAP_DELAY     = 3'd2;
    localparam logic [2:0] REG_GROWTH        = 3'd3;
    localparam logic [2:0] REG_JITTER        = 3'd4;

    // Error classes on the request side
    localparam logic [2:0] CLS_UNSPEC    = 3'd0;
    localparam logic [2:0] CLS_TRANSIENT = 3'd1;
    localparam logic [2:0] CLS_EXHAUSTED = 3'd2;
    localparam logic [2:0] CLS_PERMANENT = 3'd3;
    localparam logic [2:0] CLS_VALIDATE  = 3'd4;
    localparam logic [2:0] CLS_AUTH      = 3'd5;
    localparam logic [2:0] CLS_CANCELED  = 3'd6;
    localparam logic [2:0] CLS_OTHER     = 3'd7;

    // Result categories
    localparam logic [2:0] CAT_TRANSIENT = 3'd0;
    localparam logic [2:0] CAT_RES_LOST  = 3'd1;
    localparam logic [2:0] CAT_PERMANENT = 3'd2;
    localparam logic [2:0] CAT_VALIDATE  = 3'd3;
    localparam logic [2:0] CAT_AUTH      = 3'd4;
    localparam logic [2:0] CAT_CANCELED  = 3'd5;
    localparam logic [2:0] CAT_UNKNOWN   = 3'd6;

    // Actions
    localparam logic [1:0] ACT_RETRY = 2'd0;
    localparam logic [1:0] ACT_FAIL  = 2'd1;
    localparam logic [1:0] ACT_DEAD  = 2'd2;

    // Datapath operations issued by the controller
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_GROW_STEP = 4'd1;
    localparam logic [3:0] OP_GROW_END  = 4'd2;
    localparam logic [3:0] OP_H0        = 4'd3;
    localparam logic [3:0] OP_H1        = 4'd4;
    localparam logic [3:0] OP_H2        = 4'd5;
    localparam logic [3:0] OP_H3        = 4'd6;
    localparam logic [3:0] OP_FACT      = 4'd7;
    localparam logic [3:0] OP_FADD      = 4'd8;
    localparam logic [3:0] OP_MH        = 4'd9;
    localparam logic [3:0] OP_ML        = 4'd10;
    localparam logic [3:0] OP_FIN       = 4'd11;

    typedef struct packed {
        logic [7:0]  attempt_limit;
        logic [31:0] base_delay_ms;
        logic [31:0] cap_delay_ms;
        logic [15:0] growth_factor;
        logic [16:0] jitter_span;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic [3:0] op;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic retry;
        logic grow_busy;
        logic jit_zero;
    } status_t;

endpackage

FILE: rtl/core/retry_backoff_decider_core.sv
// Sequence: fail and dead-letter results go from the growth state straight to the output state;
// retries run one growth step per failed attempt (fewer once the cap is hit), then with jitter
// on nine shared-multiplier steps; with jitter off they go straight to the output state.
// Throughput: one request at a time, the next taken the cycle after its result is loaded,
// even while the result register waits.
// Reset (aresetn, synchronous, active low) restores register defaults and empties results.
module retry_backoff_decider_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_failed_count,
    input  logic [2:0]                  s_error_class,
    input  logic                        s_hint_present,
    input  logic                        s_hint_retry,
    input  logic [63:0]                 s_rng_seed,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_category,
    output logic [1:0]                  m_action,
    output logic [rbd_pkg::DLY_W-1:0]   m_delay_ms
);
    import rbd_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // Configuration registers
    rbd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer
    rbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic and result register
    rbd_datapath u_dp (
        .aclk           (aclk),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .s_failed_count (s_failed_count),
        .s_error_class  (s_error_class),
        .s_hint_present (s_hint_present),
        .s_hint_retry   (s_hint_retry),
        .s_rng_seed     (s_rng_seed),
        .m_category     (m_category),
        .m_action       (m_action),
        .m_delay_ms     (m_delay_ms)
    );

endmodule

FILE: rtl/core/rbd_cfg_regs.sv
// Configuration register file for the retry backoff decider.
module rbd_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output rbd_pkg::cfg_t     cfg
);
    import rbd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the register index of a write transaction
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_ATTEMPT_LIMIT: cfg_next.attempt_limit = cfg_data[7:0];
                REG_BASE_DELAY:    cfg_next.base_delay_ms = cfg_data;
                REG_CAP_DELAY:     cfg_next.cap_delay_ms  = cfg_data;
                REG_GROWTH:        cfg_next.growth_factor = cfg_data[15:0];
                REG_JITTER:        cfg_next.jitter_span   = cfg_data[16:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attempt_limit <= 8'd3;
            cfg_reg.base_delay_ms <= 32'd100;
            cfg_reg.cap_delay_ms  <= 32'd10000;
            cfg_reg.growth_factor <= 16'd512;
            cfg_reg.jitter_span   <= 17'd16384;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/rbd_datapath.sv
// Datapath: classification, backoff growth loop, jitter draw and scaling.
module rbd_datapath (
    input  logic                        aclk,
    input  rbd_pkg::cfg_t               cfg,
    input  rbd_pkg::cmd_t               cmd,
    output rbd_pkg::status_t            status,
    input  logic [7:0]                  s_failed_count,
    input  logic [2:0]                  s_error_class,
    input  logic                        s_hint_present,
    input  logic                        s_hint_retry,
    input  logic [63:0]                 s_rng_seed,
    output logic [2:0]                  m_category,
    output logic [1:0]                  m_action,
    output logic [rbd_pkg::DLY_W-1:0]   m_delay_ms
);
    import rbd_pkg::*;

    logic [2:0]          cat_reg;
    logic [1:0]          action_reg;
    logic [7:0]          cnt_reg;
    logic                stop_reg;
    logic [DQ_W-1:0]     d_reg;
    logic [63:0]         x_reg;
    logic [31:0]         acc_reg;
    logic [FACT_W-1:0]   f_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   hi_reg;
    logic [DLY_W-1:0]    delay_reg;
    logic [2:0]          m_category_reg;
    logic [1:0]          m_action_reg;
    logic [DLY_W-1:0]    m_delay_reg;

    logic [2:0]          in_cat;
    logic                in_retry;
    logic [1:0]          in_action;
    logic [63:0]         x0, x1, x2, x3;
    logic [DELAY_BITS-1:0] base_c, cap_c;
    logic [DQ_W-1:0]     capq;
    logic [DQ_W-1:0]     d_clamp;
    logic [GP_W-1:0]     grow_prod;
    logic [GP_W-1:0]     grow_next;
    logic                grow_hit;
    logic [16:0]         j_eff;
    logic [16:0]         one_minus_j;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [SUM_W-1:0]    fin_sum;

    // Class to category map
    always_comb begin
        unique case (s_error_class)
            CLS_TRANSIENT: in_cat = CAT_TRANSIENT;
            CLS_EXHAUSTED: in_cat = CAT_RES_LOST;
            CLS_PERMANENT: in_cat = CAT_PERMANENT;
            CLS_VALIDATE:  in_cat = CAT_VALIDATE;
            CLS_AUTH:      in_cat = CAT_AUTH;
            CLS_CANCELED:  in_cat = CAT_CANCELED;
            default:       in_cat = CAT_UNKNOWN;
        endcase
    end

    // Retry policy: a negative hint vetoes, unknown needs a positive hint, the attempt limit dead-letters
    always_comb begin
        if (in_cat == CAT_TRANSIENT || in_cat == CAT_RES_LOST)
            in_retry = !(s_hint_present && !s_hint_retry);
        else if (in_cat == CAT_UNKNOWN)
            in_retry = s_hint_present && s_hint_retry;
        else
            in_retry = 1'b0;
        if (!in_retry)
            in_action = ACT_FAIL;
        else if (s_failed_count >= cfg.attempt_limit)
            in_action = ACT_DEAD;
        else
            in_action = ACT_RETRY;
    end

    // xorshift64* shift-and-xor scramble of the seed
    assign x0 = (s_rng_seed == 64'd0) ? SEED_SUBST : s_rng_seed;
    assign x1 = x0 ^ (x0 >> 12);
    assign x2 = x1 ^ (x1 << 25);
    assign x3 = x2 ^ (x2 >> 27);

    // Clamp base and cap to the delay range
    assign base_c = ({32'd0, cfg.base_delay_ms} > DELAY_LIM) ? DELAY_BITS'(DELAY_LIM)
                                                               : DELAY_BITS'(cfg.base_delay_ms);
    assign cap_c  = ({32'd0, cfg.cap_delay_ms} > DELAY_LIM) ? DELAY_BITS'(DELAY_LIM)
                                                              : DELAY_BITS'(cfg.cap_delay_ms);
    assign capq    = {cap_c, 16'd0};
    assign d_clamp = (d_reg > capq) ? capq : d_reg;

    // One growth step: multiply by Q8.8 factor, overflow past 64 bits counts as cap
    assign grow_prod = GP_W'(d_reg) * GP_W'(cfg.growth_factor);
    assign grow_next = grow_prod >> 8;
    assign grow_hit  = ((grow_prod >> 64) != '0) || (grow_next >= GP_W'(capq));

    // Jitter span saturates at one
    assign j_eff       = (cfg.jitter_span > ONE_Q16) ? ONE_Q16 : cfg.jitter_span;
    assign one_minus_j = ONE_Q16 - j_eff;

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_H0: begin
                mul_a = MUL_A_W'(x_reg[31:0]);
                mul_b = MIX_MULT[31:0];
            end
            OP_H1: begin
                mul_a = MUL_A_W'(x_reg[63:32]);
                mul_b = MIX_MULT[31:0];
            end
            OP_H2: begin
                mul_a = MUL_A_W'(x_reg[31:0]);
                mul_b = MIX_MULT[63:32];
            end
            OP_FACT: begin
                mul_a = MUL_A_W'(acc_reg);
                mul_b = MUL_B_W'({j_eff, 1'b0});
            end
            OP_MH: begin
                mul_a = MUL_A_W'(d_reg[DQ_W-1:16]);
                mul_b = MUL_B_W'(f_reg);
            end
            OP_ML: begin
                mul_a = MUL_A_W'(d_reg[15:0]);
                mul_b = MUL_B_W'(f_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign fin_sum = SUM_W'(hi_reg) + SUM_W'(prod_reg >> 16);

    // Product register of the shared multiplier
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Working registers, updated per controller operation
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cat_reg    <= in_cat;
            action_reg <= in_action;
            cnt_reg    <= (s_failed_count != 8'd0) ? s_failed_count - 8'd1 : 8'd0;
            stop_reg   <= 1'b0;
            d_reg      <= {base_c, 16'd0};
            x_reg      <= x3;
            delay_reg  <= '0;
        end else begin
            unique case (cmd.op)
                OP_GROW_STEP: begin
                    cnt_reg <= cnt_reg - 8'd1;
                    if (grow_hit) begin
                        d_reg    <= capq;
                        stop_reg <= 1'b1;
                    end else begin
                        d_reg <= DQ_W'(grow_next);
                    end
                end
                OP_GROW_END: begin
                    d_reg <= d_clamp;
                    if (j_eff == 17'd0)
                        delay_reg <= DLY_W'(d_clamp >> 16);
                end
                OP_H1:   acc_reg <= prod_reg[63:32];
                OP_H2:   acc_reg <= acc_reg + prod_reg[31:0];
                OP_H3:   acc_reg <= acc_reg + prod_reg[31:0];
                OP_FADD: f_reg   <= FACT_W'(one_minus_j) + FACT_W'(prod_reg >> 32);
                OP_ML:   hi_reg  <= prod_reg;
                OP_FIN:  delay_reg <= DLY_W'(fin_sum >> 16);
                default: ;
            endcase
        end
    end

    // Result register, free-standing from the working registers
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_category_reg <= cat_reg;
            m_action_reg   <= action_reg;
            m_delay_reg    <= delay_reg;
        end
    end

    assign m_category = m_category_reg;
    assign m_action   = m_action_reg;
    assign m_delay_ms = m_delay_reg;

    assign status.retry     = (action_reg == ACT_RETRY);
    assign status.grow_busy = (cnt_reg != 8'd0) && !stop_reg;
    assign status.jit_zero  = (j_eff == 17'd0);

endmodule

FILE: rtl/core/rbd_ctrl.sv
// Controller state machine sequencing the datapath and both handshakes.
module rbd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  rbd_pkg::status_t   status,
    output rbd_pkg::cmd_t      cmd
);
    import rbd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GROW = 4'd1;
    localparam logic [3:0] S_H0   = 4'd2;
    localparam logic [3:0] S_H1   = 4'd3;
    localparam logic [3:0] S_H2   = 4'd4;
    localparam logic [3:0] S_H3   = 4'd5;
    localparam logic [3:0] S_FACT = 4'd6;
    localparam logic [3:0] S_FADD = 4'd7;
    localparam logic [3:0] S_MH   = 4'd8;
    localparam logic [3:0] S_ML   = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       slot_free;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign slot_free = !m_valid_reg || m_ready;

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.load     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_GROW;
                end
            end
            S_GROW: begin
                if (!status.retry) begin
                    state_next = S_OUT;
                end else if (status.grow_busy) begin
                    cmd.op = OP_GROW_STEP;
                end else begin
                    cmd.op     = OP_GROW_END;
                    state_next = status.jit_zero ? S_OUT : S_H0;
                end
            end
            S_H0: begin
                cmd.op     = OP_H0;
                state_next = S_H1;
            end
            S_H1: begin
                cmd.op     = OP_H1;
                state_next = S_H2;
            end
            S_H2: begin
                cmd.op     = OP_H2;
                state_next = S_H3;
            end
            S_H3: begin
                cmd.op     = OP_H3;
                state_next = S_FACT;
            end
            S_FACT: begin
                cmd.op     = OP_FACT;
                state_next = S_FADD;
            end
            S_FADD: begin
                cmd.op     = OP_FADD;
                state_next = S_MH;
            end
            S_MH: begin
                cmd.op     = OP_MH;
                state_next = S_ML;
            end
            S_ML: begin
                cmd.op     = OP_ML;
                state_next = S_FIN;
            end
            S_FIN: begin
                cmd.op     = OP_FIN;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
